>>> src/ecpm_pkg.sv
// Shared types, constants and CORDIC tables for the equirect perspective coordinate map.
package ecpm_pkg;

    // CORDIC datapath width and trig result width (Q30)
    localparam int DW       = 36;
    localparam int TW       = 32;
    localparam int CORDIC_N = 30;

    localparam logic signed [DW-1:0] TURN_HALF    = 36'sd2147483648;
    localparam logic signed [DW-1:0] TURN_QUARTER = 36'sd1073741824;
    localparam logic signed [DW-1:0] CORDIC_K     = 36'sd652032875;

    // atan(2^-i) as binary angles, 2^32 per turn
    localparam logic signed [DW-1:0] ATAN_TAB [CORDIC_N] = '{
        36'sd536870912, 36'sd316933406, 36'sd167458907, 36'sd85004756,
        36'sd42667331, 36'sd21354465, 36'sd10679838, 36'sd5340245,
        36'sd2670163, 36'sd1335087, 36'sd667544, 36'sd333772,
        36'sd166886, 36'sd83443, 36'sd41722, 36'sd20861,
        36'sd10430, 36'sd5215, 36'sd2608, 36'sd1304,
        36'sd652, 36'sd326, 36'sd163, 36'sd81,
        36'sd41, 36'sd20, 36'sd10, 36'sd5,
        36'sd3, 36'sd1
    };

    // configuration register indexes
    localparam logic [2:0] REG_YAW    = 3'd0;
    localparam logic [2:0] REG_PITCH  = 3'd1;
    localparam logic [2:0] REG_FOV    = 3'd2;
    localparam logic [2:0] REG_VIEW_W = 3'd3;
    localparam logic [2:0] REG_VIEW_H = 3'd4;
    localparam logic [2:0] REG_PANO_W = 3'd5;
    localparam logic [2:0] REG_PANO_H = 3'd6;

    // angle slots of the trig sequencer
    localparam logic [1:0] ANG_FOV   = 2'd0;
    localparam logic [1:0] ANG_PITCH = 2'd1;
    localparam logic [1:0] ANG_YAW   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_ROT
    } trig_state_t;

    // sin/cos of half fov, pitch and yaw, Q30
    typedef struct packed {
        logic signed [TW-1:0] hc;
        logic signed [TW-1:0] hs;
        logic signed [TW-1:0] cp;
        logic signed [TW-1:0] sp;
        logic signed [TW-1:0] cy;
        logic signed [TW-1:0] sy;
    } trig_t;

endpackage

>>> src/ecpm_trig.sv
// Sequential unit: centidegree to binary angle conversion and CORDIC sin/cos of view angles.
module ecpm_trig (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [14:0]     fov,
    input  logic [14:0]     pitch,
    input  logic [15:0]     yaw,
    output logic            busy,
    output ecpm_pkg::trig_t trig
);
    import ecpm_pkg::*;

    // cd * 2^32 / 36000 = cd * A + (cd * B) / 36000; half fov uses 2^31
    localparam logic [16:0] TURN_A      = 17'd119304;
    localparam logic [14:0] TURN_B      = 15'd23296;
    localparam logic [16:0] HALF_A      = 17'd59652;
    localparam logic [14:0] HALF_B      = 15'd11648;
    localparam logic [29:0] ROUND_HALF  = 30'd18000;
    // floor(n / 1125) = (n * DIV_M) >> 36 for n below 2^25
    localparam logic [25:0] DIV_M       = 26'd61083980;
    localparam logic [5:0]  DIV_LAST    = 6'd1;

    trig_state_t          state_reg, state_next;
    logic [1:0]           idx_reg;
    logic [5:0]           cnt_reg;
    logic [31:0]          hi_reg;
    logic [29:0]          lo_reg;
    logic [50:0]          prod_reg;
    logic [31:0]          quo_reg;
    logic                 neg_reg;
    logic                 fneg_reg;
    logic signed [DW-1:0] cx_reg, cy_reg, cz_reg;
    trig_t                trig_reg;

    logic [1:0]           load_idx;
    logic signed [16:0]   load_cd;
    logic [16:0]          load_a;
    logic [14:0]          load_b;
    logic [15:0]          load_mag;
    logic [32:0]          hi_prod;
    logic [30:0]          lo_prod;
    logic [31:0]          load_hi;
    logic [29:0]          load_lo;
    logic [14:0]          fov_c;
    logic [31:0]          q_ang;
    logic signed [DW-1:0] za;
    logic signed [DW-1:0] dx, dy;
    logic signed [DW-1:0] cx_next, cy_next, cz_next;
    logic signed [DW-1:0] co_fin, si_fin;

    // angle to be loaded next, split into whole and remainder parts
    always_comb
    begin
        load_idx = (state_reg == ST_IDLE) ? ANG_FOV : idx_reg + 2'd1;
        if (fov < 15'd100)
            fov_c = 15'd100;
        else if (fov > 15'd17900)
            fov_c = 15'd17900;
        else
            fov_c = fov;
        unique case (load_idx)
            ANG_FOV:
            begin
                load_cd = $signed({2'b00, fov_c});
                load_a  = HALF_A;
                load_b  = HALF_B;
            end
            ANG_PITCH:
            begin
                load_cd = 17'($signed(pitch));
                load_a  = TURN_A;
                load_b  = TURN_B;
            end
            default:
            begin
                load_cd = 17'($signed(yaw));
                load_a  = TURN_A;
                load_b  = TURN_B;
            end
        endcase
        load_mag = load_cd[16] ? 16'(-load_cd) : load_cd[15:0];
        hi_prod  = load_mag * load_a;
        lo_prod  = load_mag * load_b;
        load_hi  = hi_prod[31:0];
        load_lo  = lo_prod[29:0] + ROUND_HALF;
    end

    // quotient to signed angle; the fold into the right half plane follows in ST_PREP
    always_comb
    begin
        q_ang = neg_reg ? 32'(-quo_reg) : quo_reg;
        za    = DW'($signed(q_ang));
    end

    // rotation step
    always_comb
    begin
        dx = cy_reg >>> cnt_reg[4:0];
        dy = cx_reg >>> cnt_reg[4:0];
        if (cz_reg >= 0)
        begin
            cx_next = cx_reg - dx;
            cy_next = cy_reg + dy;
            cz_next = cz_reg - ATAN_TAB[cnt_reg[4:0]];
        end
        else
        begin
            cx_next = cx_reg + dx;
            cy_next = cy_reg - dy;
            cz_next = cz_reg + ATAN_TAB[cnt_reg[4:0]];
        end
        co_fin = fneg_reg ? -cx_next : cx_next;
        si_fin = fneg_reg ? -cy_next : cy_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == DIV_LAST) state_next = ST_PREP;
            ST_PREP: state_next = ST_ROT;
            ST_ROT:
            begin
                if (cnt_reg == 6'(CORDIC_N - 1))
                    state_next = (idx_reg == ANG_YAW) ? ST_IDLE : ST_DIV;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy = (state_reg != ST_IDLE);
        trig = trig_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= ANG_FOV;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (start)
                        idx_reg <= load_idx;
                end
                ST_DIV:  cnt_reg <= (cnt_reg == DIV_LAST) ? 6'd0 : cnt_reg + 6'd1;
                ST_PREP: cnt_reg <= '0;
                ST_ROT:
                begin
                    if (cnt_reg == 6'(CORDIC_N - 1))
                    begin
                        cnt_reg <= '0;
                        if (idx_reg != ANG_YAW)
                            idx_reg <= load_idx;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                default: cnt_reg <= '0;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                hi_reg  <= load_hi;
                lo_reg  <= load_lo;
                neg_reg <= load_cd[16];
            end
            ST_DIV:
            begin
                // remainder part by reciprocal, then add the whole part
                prod_reg <= lo_reg[29:5] * DIV_M;
                quo_reg  <= hi_reg + {17'd0, prod_reg[50:36]};
            end
            ST_PREP:
            begin
                cx_reg <= CORDIC_K;
                cy_reg <= '0;
                if (za > TURN_QUARTER)
                begin
                    cz_reg   <= za - TURN_HALF;
                    fneg_reg <= 1'b1;
                end
                else if (za < -TURN_QUARTER)
                begin
                    cz_reg   <= za + TURN_HALF;
                    fneg_reg <= 1'b1;
                end
                else
                begin
                    cz_reg   <= za;
                    fneg_reg <= 1'b0;
                end
            end
            ST_ROT:
            begin
                cx_reg <= cx_next;
                cy_reg <= cy_next;
                cz_reg <= cz_next;
                if (cnt_reg == 6'(CORDIC_N - 1))
                begin
                    hi_reg  <= load_hi;
                    lo_reg  <= load_lo;
                    neg_reg <= load_cd[16];
                    unique case (idx_reg)
                        ANG_FOV:
                        begin
                            trig_reg.hc <= co_fin[TW-1:0];
                            trig_reg.hs <= si_fin[TW-1:0];
                        end
                        ANG_PITCH:
                        begin
                            trig_reg.cp <= co_fin[TW-1:0];
                            trig_reg.sp <= si_fin[TW-1:0];
                        end
                        default:
                        begin
                            trig_reg.cy <= co_fin[TW-1:0];
                            trig_reg.sy <= si_fin[TW-1:0];
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

endmodule

>>> src/ecpm_vec.sv
// Pipelined CORDIC vectoring unit: angle and gained magnitude of (x, y), one stage per step.
module ecpm_vec (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [ecpm_pkg::DW-1:0] in_x,
    input  logic signed [ecpm_pkg::DW-1:0] in_y,
    input  logic signed [ecpm_pkg::DW-1:0] in_side,
    output logic                          out_valid,
    output logic signed [ecpm_pkg::DW-1:0] out_ang,
    output logic signed [ecpm_pkg::DW-1:0] out_mag,
    output logic signed [ecpm_pkg::DW-1:0] out_side
);
    import ecpm_pkg::*;

    logic                 val_reg  [CORDIC_N+1];
    logic                 zero_reg [CORDIC_N+1];
    logic signed [DW-1:0] x_reg    [CORDIC_N+1];
    logic signed [DW-1:0] y_reg    [CORDIC_N+1];
    logic signed [DW-1:0] z_reg    [CORDIC_N+1];
    logic signed [DW-1:0] side_reg [CORDIC_N+1];

    // valid bits travel with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= CORDIC_N; i++)
                val_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            val_reg[0] <= in_valid;
            for (int i = 0; i < CORDIC_N; i++)
                val_reg[i+1] <= val_reg[i];
        end
    end

    // entry stage folds the left half plane, then one micro-rotation per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (in_x == 0) && (in_y == 0);
            side_reg[0] <= in_side;
            if (in_x < 0)
            begin
                x_reg[0] <= -in_x;
                y_reg[0] <= -in_y;
                z_reg[0] <= (in_y >= 0) ? TURN_HALF : -TURN_HALF;
            end
            else
            begin
                x_reg[0] <= in_x;
                y_reg[0] <= in_y;
                z_reg[0] <= '0;
            end
            for (int i = 0; i < CORDIC_N; i++)
            begin
                zero_reg[i+1] <= zero_reg[i];
                side_reg[i+1] <= side_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end
            end
        end
    end

    // a zero-length vector reports angle 0, magnitude 0
    assign out_valid = val_reg[CORDIC_N];
    assign out_ang   = zero_reg[CORDIC_N] ? '0 : z_reg[CORDIC_N];
    assign out_mag   = zero_reg[CORDIC_N] ? '0 : x_reg[CORDIC_N];
    assign out_side  = side_reg[CORDIC_N];

endmodule

>>> src/equirect_perspective_coord_map.sv
// Top level: view pixel to equirectangular source coordinate pipeline.
//
// Usage: write the view registers on the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data), then stream view pixels (col_index, row_index) on the input channel; each
// input beat yields one output beat (src_u, src_v) with FRAC_BITS fractional bits.
// Both data channels use valid/stall; a beat moves when valid is high and stall low.
// Throughput: one beat per cycle while in_stall is low. The path from input beat to
// output valid runs through the two 31-stage CORDIC vectoring pipelines plus the
// projection, rotation, gain, scaling and rounding stages and the output register.
// After reset and after every register write, a sequential trig unit recomputes
// sin/cos of half fov, pitch and yaw (three passes of a 2-step reciprocal divide,
// a setup step and a 30-step CORDIC); in_stall and cfg_ready hold off
// beats meanwhile.
// When the receiver stalls, the result waits in the output register and one more
// lands in a skid register; only then does the pipeline freeze and in_stall rise.
// No beat is lost or repeated.
module equirect_perspective_coord_map #(
    parameter int MAX_VIEW_DIM   = 4096,
    parameter int MAX_PANO_WIDTH = 8192,
    parameter int FRAC_BITS      = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] col_index,
    input  logic [11:0] row_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] src_u,
    output logic [20:0] src_v
);
    import ecpm_pkg::*;

    // configuration registers
    logic [15:0] yaw_angle_reg;
    logic [14:0] pitch_angle_reg;
    logic [14:0] field_of_view_reg;
    logic [12:0] view_width_reg;
    logic [12:0] view_height_reg;
    logic [13:0] pano_width_reg;
    logic [12:0] pano_height_reg;
    logic        dirty_reg, dirty_next;

    logic        cfg_wr;
    logic        trig_busy;
    logic        trig_start;
    trig_t       trig;
    logic        en;
    logic        in_acc;

    assign cfg_ready  = !trig_busy;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign trig_start = dirty_reg && !trig_busy;

    always_comb
    begin
        if (cfg_wr)
            dirty_next = 1'b1;
        else if (trig_start)
            dirty_next = 1'b0;
        else
            dirty_next = dirty_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_angle_reg     <= 16'd0;
            pitch_angle_reg   <= 15'd0;
            field_of_view_reg <= 15'd9000;
            view_width_reg    <= 13'd640;
            view_height_reg   <= 13'd480;
            pano_width_reg    <= 14'd2048;
            pano_height_reg   <= 13'd1024;
            dirty_reg         <= 1'b1;
        end
        else
        begin
            dirty_reg <= dirty_next;
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    REG_YAW:    yaw_angle_reg     <= cfg_data;
                    REG_PITCH:  pitch_angle_reg   <= cfg_data[14:0];
                    REG_FOV:    field_of_view_reg <= cfg_data[14:0];
                    REG_VIEW_W: view_width_reg    <= cfg_data[12:0];
                    REG_VIEW_H: view_height_reg   <= cfg_data[12:0];
                    REG_PANO_W: pano_width_reg    <= cfg_data[13:0];
                    REG_PANO_H: pano_height_reg   <= cfg_data[12:0];
                    default: ;
                endcase
            end
        end
    end

    ecpm_trig u_trig (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .fov   (field_of_view_reg),
        .pitch (pitch_angle_reg),
        .yaw   (yaw_angle_reg),
        .busy  (trig_busy),
        .trig  (trig)
    );

    // limited sizes
    logic [12:0] w_eff, h_eff;
    logic [13:0] pw_eff;

    always_comb
    begin
        w_eff  = (32'(view_width_reg) > 32'(MAX_VIEW_DIM)) ? 13'(MAX_VIEW_DIM) : view_width_reg;
        h_eff  = (32'(view_height_reg) > 32'(MAX_VIEW_DIM)) ?
                 13'(MAX_VIEW_DIM) : view_height_reg;
        pw_eff = (32'(pano_width_reg) > 32'(MAX_PANO_WIDTH)) ?
                 14'(MAX_PANO_WIDTH) : pano_width_reg;
    end

    function automatic logic signed [33:0] mulq30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b + 64'sd536870912;
        return p[63:30];
    endfunction

    // skid state drives the pipeline enable
    logic skid_full_reg;
    assign en       = !skid_full_reg;
    assign in_stall = trig_busy || dirty_reg || skid_full_reg;
    assign in_acc   = in_valid && !in_stall;

    // stage 1: view ray, x and y scaled by sin(fov/2), z by cos(fov/2)
    logic signed [14:0] dx_s, dy_s;
    logic signed [13:0] dz_s;
    logic signed [46:0] px, py;
    logic signed [45:0] pz;
    logic               s1_valid_reg;
    logic signed [31:0] s1_x_reg, s1_y_reg, s1_z_reg;

    always_comb
    begin
        dx_s = $signed({2'b00, col_index, 1'b0}) - $signed({2'b00, w_eff});
        dy_s = $signed({2'b00, row_index, 1'b0}) - $signed({2'b00, h_eff});
        dz_s = $signed({1'b0, w_eff});
        px   = dx_s * trig.hs;
        py   = dy_s * trig.hs;
        pz   = dz_s * trig.hc;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg <= $signed(px[45:14]);
            s1_y_reg <= $signed(py[45:14]);
            s1_z_reg <= $signed(pz[45:14]);
        end
    end

    // stage 2: pitch products
    logic               s2_valid_reg;
    logic signed [33:0] s2_yc_reg, s2_zs_reg, s2_ys_reg, s2_zc_reg;
    logic signed [31:0] s2_x_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_yc_reg <= mulq30(s1_y_reg, trig.cp);
            s2_zs_reg <= mulq30(s1_z_reg, trig.sp);
            s2_ys_reg <= mulq30(s1_y_reg, trig.sp);
            s2_zc_reg <= mulq30(s1_z_reg, trig.cp);
            s2_x_reg  <= s1_x_reg;
        end
    end

    // stage 3: pitch sums
    logic               s3_valid_reg;
    logic signed [31:0] s3_x_reg, s3_y_reg, s3_z_reg;
    logic signed [33:0] y2_sum, z2_sum;

    assign y2_sum = s2_yc_reg - s2_zs_reg;
    assign z2_sum = s2_ys_reg + s2_zc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_x_reg <= s2_x_reg;
            s3_y_reg <= $signed(y2_sum[31:0]);
            s3_z_reg <= $signed(z2_sum[31:0]);
        end
    end

    // stage 4: yaw products
    logic               s4_valid_reg;
    logic signed [33:0] s4_xc_reg, s4_zs_reg, s4_zc_reg, s4_xs_reg;
    logic signed [31:0] s4_y_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_xc_reg <= mulq30(s3_x_reg, trig.cy);
            s4_zs_reg <= mulq30(s3_z_reg, trig.sy);
            s4_zc_reg <= mulq30(s3_z_reg, trig.cy);
            s4_xs_reg <= mulq30(s3_x_reg, trig.sy);
            s4_y_reg  <= s3_y_reg;
        end
    end

    // stage 5: yaw sums
    logic               s5_valid_reg;
    logic signed [31:0] s5_x_reg, s5_z_reg, s5_y_reg;
    logic signed [33:0] x3_sum, z3_sum;

    assign x3_sum = s4_xc_reg + s4_zs_reg;
    assign z3_sum = s4_zc_reg - s4_xs_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_x_reg <= $signed(x3_sum[31:0]);
            s5_z_reg <= $signed(z3_sum[31:0]);
            s5_y_reg <= s4_y_reg;
        end
    end

    // longitude
    logic                 v1_valid;
    logic signed [DW-1:0] v1_ang, v1_mag, v1_side;

    ecpm_vec u_vec_lon (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_valid_reg),
        .in_x      (DW'(s5_z_reg)),
        .in_y      (DW'(s5_x_reg)),
        .in_side   (DW'(s5_y_reg)),
        .out_valid (v1_valid),
        .out_ang   (v1_ang),
        .out_mag   (v1_mag),
        .out_side  (v1_side)
    );

    // stage 6: remove CORDIC gain from horizontal magnitude
    logic                 s6_valid_reg;
    logic signed [DW-1:0] s6_r_reg, s6_lon_reg, s6_y_reg;
    logic [61:0]          r_prod;

    assign r_prod = v1_mag[31:0] * CORDIC_K[29:0] + 62'd536870912;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_r_reg   <= $signed({4'd0, r_prod[61:30]});
            s6_lon_reg <= v1_ang;
            s6_y_reg   <= v1_side;
        end
    end

    // latitude
    logic                 v2_valid;
    logic signed [DW-1:0] v2_ang, v2_mag, v2_side;

    ecpm_vec u_vec_lat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_valid_reg),
        .in_x      (s6_r_reg),
        .in_y      (s6_y_reg),
        .in_side   (s6_lon_reg),
        .out_valid (v2_valid),
        .out_ang   (v2_ang),
        .out_mag   (v2_mag),
        .out_side  (v2_side)
    );

    // stage 7: clamp latitude, scale by panorama size
    logic                 s7_valid_reg;
    logic [45:0]          s7_u_reg;
    logic [44:0]          s7_v_reg;
    logic signed [DW-1:0] lat_c, v_diff;
    logic [31:0]          ua, va;

    always_comb
    begin
        if (v2_ang > TURN_QUARTER)
            lat_c = TURN_QUARTER;
        else if (v2_ang < -TURN_QUARTER)
            lat_c = -TURN_QUARTER;
        else
            lat_c = v2_ang;
        v_diff = TURN_QUARTER - lat_c;
        va     = v_diff[31:0];
        ua     = v2_side[31:0] + 32'h8000_0000;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_u_reg <= ua * pw_eff;
            s7_v_reg <= va * pano_height_reg;
        end
    end

    // stage 8: round, wrap u, mask
    logic        s8_valid_reg;
    logic [20:0] s8_u_reg, s8_v_reg;
    logic [47:0] u_rnd, uf, uf_w, pw_lim, v_rnd, vf;

    always_comb
    begin
        u_rnd  = {2'b00, s7_u_reg} + (48'd1 << (31 - FRAC_BITS));
        uf     = u_rnd >> (32 - FRAC_BITS);
        pw_lim = 48'(pw_eff) << FRAC_BITS;
        uf_w   = (uf >= pw_lim) ? uf - pw_lim : uf;
        v_rnd  = {3'b000, s7_v_reg} + (48'd1 << (30 - FRAC_BITS));
        vf     = v_rnd >> (31 - FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_u_reg <= uf_w[20:0];
            s8_v_reg <= vf[20:0];
        end
    end

    // valid bits of the local stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_acc;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= v1_valid;
            s7_valid_reg <= v2_valid;
            s8_valid_reg <= s7_valid_reg;
        end
    end

    // output register with skid
    logic        out_valid_reg, out_valid_next;
    logic        skid_full_next;
    logic [20:0] out_u_reg, out_v_reg, skid_u_reg, skid_v_reg;
    logic        out_take;
    logic        load_out, load_skid, load_from_skid;

    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        load_out       = 1'b0;
        load_skid      = 1'b0;
        load_from_skid = 1'b0;
        out_valid_next = out_valid_reg;
        skid_full_next = skid_full_reg;
        priority if (skid_full_reg)
        begin
            if (out_take)
            begin
                load_from_skid = 1'b1;
                skid_full_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            load_out       = 1'b1;
            out_valid_next = s8_valid_reg;
        end
        else if (s8_valid_reg)
        begin
            load_skid      = 1'b1;
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_u_reg <= s8_u_reg;
            out_v_reg <= s8_v_reg;
        end
        else if (load_from_skid)
        begin
            out_u_reg <= skid_u_reg;
            out_v_reg <= skid_v_reg;
        end
        if (load_skid)
        begin
            skid_u_reg <= s8_u_reg;
            skid_v_reg <= s8_v_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign src_u     = out_u_reg;
    assign src_v     = out_v_reg;

    // checks
    a_no_beat_during_trig: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> !trig_busy && !dirty_reg)
        else $error("input beat accepted while trig unit is not settled");

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid holds a beat while output register is empty");

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> in_stall)
        else $error("input not held off after a register write");

endmodule

>>> sim/ecpm_checker.sv
// Checker for the coordinate map: tracks register writes, predicts source coordinates, compares.
`timescale 1ns / 100ps

module ecpm_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [11:0] col_index,
    input  logic [11:0] row_index,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [20:0] src_u,
    input  logic [20:0] src_v,
    output int          fail_count,
    output int          pending
);
    import ecpm_pkg::*;

    typedef struct {
        logic [20:0] u;
        logic [20:0] v;
    } coord_t;

    coord_t coord_q[$];

    // shadow copy of the view registers
    logic signed [15:0] yaw_r;
    logic signed [14:0] pitch_r;
    logic [14:0]        fov_r;
    logic [12:0]        vw_r;
    logic [12:0]        vh_r;
    logic [13:0]        pw_r;
    logic [12:0]        ph_r;

    localparam longint HALF    = 64'sd2147483648;
    localparam longint QUARTER = 64'sd1073741824;
    localparam longint KGAIN   = 64'sd652032875;
    localparam longint RND29   = 64'sd536870912;

    // centidegrees to 32-bit binary angle, ties away from zero
    function automatic longint to_bangle(longint cd, longint denom);
        longint n;
        longint mag;
        longint q;
        logic [31:0] wrapped;
        n = cd * 64'sd4294967296;
        mag = (n < 0) ? -n : n;
        q = (mag + denom / 2) / denom;
        if (n < 0)
            q = -q;
        wrapped = q[31:0];
        return longint'($signed(wrapped));
    endfunction

    // rotation-mode CORDIC, Q30 cos/sin
    task automatic trig_of(input longint a, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     neg;
        z = a;
        x = KGAIN;
        y = 0;
        neg = 0;
        if (z > QUARTER) begin
            z -= HALF;
            neg = 1;
        end else if (z < -QUARTER) begin
            z += HALF;
            neg = 1;
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    // vectoring-mode CORDIC: angle of (x, y) and gained magnitude
    task automatic angle_of(input longint xi, input longint yi,
                            output longint ang, output longint mag);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = xi;
        y = yi;
        z = 0;
        if (x == 0 && y == 0) begin
            ang = 0;
            mag = 0;
            return;
        end
        if (x < 0) begin
            z = (y >= 0) ? HALF : -HALF;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
        end
        ang = z;
        mag = x;
    endtask

    function automatic longint mul_q30(longint a, longint b);
        return (a * b + RND29) >>> 30;
    endfunction

    // project one view pixel into the panorama
    task automatic map_pixel(input logic [11:0] col, input logic [11:0] row,
                             output coord_t res);
        longint w, h, pw, ph, fov;
        longint hc, hs, cp, sp, cy, sy;
        longint x, y, z, y2, z2, x3, z3, lon, lat, m, r, ua, uf, va, vf;
        w = (vw_r > 4096) ? 4096 : longint'(vw_r);
        h = (vh_r > 4096) ? 4096 : longint'(vh_r);
        pw = (pw_r > 8192) ? 8192 : longint'(pw_r);
        ph = longint'(ph_r);
        fov = longint'(fov_r);
        if (fov < 100)
            fov = 100;
        if (fov > 17900)
            fov = 17900;
        trig_of(to_bangle(fov, 72000), hc, hs);
        trig_of(to_bangle(longint'(pitch_r), 36000), cp, sp);
        trig_of(to_bangle(longint'(yaw_r), 36000), cy, sy);

        x = ((2 * longint'(col) - w) * hs) >>> 14;
        y = ((2 * longint'(row) - h) * hs) >>> 14;
        z = (w * hc) >>> 14;

        // pitch about X, then yaw about Y
        y2 = mul_q30(y, cp) - mul_q30(z, sp);
        z2 = mul_q30(y, sp) + mul_q30(z, cp);
        x3 = mul_q30(x, cy) + mul_q30(z2, sy);
        z3 = mul_q30(z2, cy) - mul_q30(x, sy);

        angle_of(z3, x3, lon, m);
        r = (m * KGAIN + RND29) >>> 30;
        angle_of(r, y2, lat, m);
        if (lat > QUARTER)
            lat = QUARTER;
        if (lat < -QUARTER)
            lat = -QUARTER;

        ua = (lon + HALF) & 64'hFFFF_FFFF;
        uf = (ua * pw + (64'sd1 << 23)) >> 24;
        if (uf >= (pw << 8))
            uf -= (pw << 8);
        va = QUARTER - lat;
        vf = (va * ph + (64'sd1 << 22)) >> 23;
        res.u = uf[20:0];
        res.v = vf[20:0];
    endtask

    assign pending = coord_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        coord_t want;
        coord_t got;
        if (!rst_n) begin
            yaw_r   <= '0;
            pitch_r <= '0;
            fov_r   <= 15'd9000;
            vw_r    <= 13'd640;
            vh_r    <= 13'd480;
            pw_r    <= 14'd2048;
            ph_r    <= 13'd1024;
            fail_count <= 0;
            coord_q.delete();
        end else begin
            // result beat
            if (out_valid && !out_stall) begin
                if (coord_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat u=%0d v=%0d", src_u, src_v);
                    fail_count <= fail_count + 1;
                end else begin
                    want = coord_q.pop_front();
                    got.u = src_u;
                    got.v = src_v;
                    if (got.u !== want.u || got.v !== want.v) begin
                        if (fail_count < 10)
                            $display("mismatch: u exp %0d got %0d, v exp %0d got %0d",
                                     want.u, got.u, want.v, got.v);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // pixel beat
            if (in_valid && !in_stall) begin
                map_pixel(col_index, row_index, want);
                coord_q.push_back(want);
            end
            // register write
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_YAW:    yaw_r   <= cfg_data;
                    REG_PITCH:  pitch_r <= cfg_data[14:0];
                    REG_FOV:    fov_r   <= cfg_data[14:0];
                    REG_VIEW_W: vw_r    <= cfg_data[12:0];
                    REG_VIEW_H: vh_r    <= cfg_data[12:0];
                    REG_PANO_W: pw_r    <= cfg_data[13:0];
                    REG_PANO_H: ph_r    <= cfg_data[12:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> sim/testbench.sv
// Testbench top: clock, reset, stimulus and verdict for the coordinate map.
`timescale 1ns / 100ps

module testbench;
    import ecpm_pkg::*;

    localparam int WATCHDOG  = 20000;
    localparam int DRAIN_CYC = 100;

    // index outside the register list
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [11:0] col_index;
    logic [11:0] row_index;
    logic        out_valid;
    logic        out_stall;
    logic [20:0] src_u;
    logic [20:0] src_v;

    int fail_count;
    int pending;
    int idle_mode;
    int sent;
    int quiet;
    int view_w;
    int view_h;
    logic in_taken;
    logic cfg_taken;
    logic out_taken;

    equirect_perspective_coord_map dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .col_index(col_index), .row_index(row_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .src_u(src_u), .src_v(src_v)
    );

    ecpm_checker chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .col_index(col_index), .row_index(row_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .src_u(src_u), .src_v(src_v),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // handshake flags as seen at the last rising edge
    always @(posedge clk)
    begin
        in_taken  <= in_valid && !in_stall;
        cfg_taken <= cfg_valid && cfg_ready;
        out_taken <= out_valid && !out_stall;
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (cfg_valid && cfg_ready)
            || (out_valid && !out_stall))
            quiet <= 0;
        else if (quiet >= WATCHDOG) begin
            $display("** equirect_perspective_coord_map: FAILED **");
            $finish;
        end else
            quiet <= quiet + 1;
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            case (idle_mode)
                0: out_stall <= ($urandom_range(0, 99) < 67);
                1: out_stall <= ($urandom_range(0, 99) < 26);
                default: out_stall <= 1'b0;
            endcase
    end

    function automatic bit sender_idles();
        case (idle_mode)
            0: return $urandom_range(0, 99) < 26;
            1: return $urandom_range(0, 99) < 67;
            default: return 0;
        endcase
    endfunction

    // one pixel beat; called and returns at a falling edge
    task automatic send_pixel(input logic [11:0] c, input logic [11:0] r);
        while (sender_idles()) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        col_index = c;
        row_index = r;
        @(negedge clk);
        while (!in_taken)
            @(negedge clk);
        sent++;
        if (sent > 666)
            idle_mode = 2;
        else if (sent > 333)
            idle_mode = 1;
    endtask

    // drain the pipeline, then write one register
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        while (!cfg_taken)
            @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == REG_VIEW_W)
            view_w = (val[12:0] > 4096) ? 4096 : val[12:0];
        if (idx == REG_VIEW_H)
            view_h = (val[12:0] > 4096) ? 4096 : val[12:0];
    endtask

    task automatic write_view(input logic [15:0] yaw, input logic [15:0] pitch,
                              input logic [15:0] fov, input logic [15:0] vw,
                              input logic [15:0] vh, input logic [15:0] pw,
                              input logic [15:0] ph);
        write_reg(REG_YAW, yaw);
        write_reg(REG_PITCH, pitch);
        write_reg(REG_FOV, fov);
        write_reg(REG_VIEW_W, vw);
        write_reg(REG_VIEW_H, vh);
        write_reg(REG_PANO_W, pw);
        write_reg(REG_PANO_H, ph);
    endtask

    // top-left corner, view center and two pixels at the 4095 index limit
    task automatic send_corners();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'(view_w / 2), 12'(view_h / 2));
        send_pixel(12'd0, 12'hFFF);
    endtask

    function automatic logic [11:0] in_view(int lim);
        if (lim <= 0)
            return 12'd0;
        return 12'($urandom_range(0, (lim > 4096 ? 4096 : lim) - 1));
    endfunction

    initial
    begin
        logic [15:0] yaw, pitch, fov, vw, vh, pw, ph;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        col_index = '0;
        row_index = '0;
        idle_mode = 0;
        sent = 0;
        view_w = 640;
        view_h = 480;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset settings
        send_corners();
        send_pixel(12'd320, 12'd0);
        send_pixel(12'd639, 12'd479);
        send_pixel(12'd0, 12'd240);
        send_pixel(12'd4095, 12'd0);
        // upper extremes
        write_view(16'd18000, 16'd9000, 16'd17900, 16'd4096, 16'd4096, 16'd8192, 16'd4096);
        send_corners();
        // lower extremes
        write_view(-16'sd18000, -16'sd9000, 16'd100, 16'd1, 16'd1, 16'd1, 16'd1);
        send_corners();
        // yaw past half turn, pitch past quarter turn, fov 0, too wide, rest zero
        write_view(16'h7FFF, 16'h3FFF, 16'd0, 16'd8191, 16'd0, 16'd0, 16'd0);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_corners();
        // fov above range, pano width above limit, zero view width
        write_view(16'h8000, 16'hC000, 16'hFFFF, 16'd0, 16'd8191, 16'd16383, 16'd8191);
        send_corners();

        // random phases
        for (int ph_i = 0; ph_i < 10; ph_i++) begin
            yaw   = 16'($urandom_range(0, 36000) - 18000);
            pitch = 16'($urandom_range(0, 18000) - 9000);
            fov   = 16'($urandom_range(100, 17900));
            vw    = 16'($urandom_range(1, 4096));
            vh    = 16'($urandom_range(1, 4096));
            pw    = 16'($urandom_range(1, 8192));
            ph    = 16'($urandom_range(1, 4096));
            if ($urandom_range(0, 3) == 0) begin
                yaw = 16'($urandom);
                pitch = 16'($urandom);
                fov = 16'($urandom);
                pw = 16'($urandom);
            end
            write_view(yaw, pitch, fov, vw, vh, pw, ph);
            for (int k = 0; k < 98; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_pixel(12'($urandom), 12'($urandom));
                else
                    send_pixel(in_view(view_w), in_view(view_h));
            end
        end

        // wind down
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** equirect_perspective_coord_map: PASSED **");
        else
            $display("** equirect_perspective_coord_map: FAILED **");
        $finish;
    end

endmodule

>>> files.f
src/ecpm_pkg.sv
src/ecpm_trig.sv
src/ecpm_vec.sv
src/equirect_perspective_coord_map.sv
sim/ecpm_checker.sv
sim/testbench.sv
